// File: rtl/core/dbf_pkg.sv
package dbf_pkg;

   // configuration register indexes
   localparam int unsigned CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CsrAlphaOffset = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrBetaOffset  = 1'b1;

   localparam logic [5:0] MaxIndex  = 6'd51;
   localparam logic [2:0] StrongBs  = 3'd4;

   localparam logic [7:0] AlphaTab [52] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,
      8'd12,  8'd13,  8'd15,  8'd17,  8'd20,  8'd22,  8'd25,  8'd28,
      8'd32,  8'd36,  8'd40,  8'd45,  8'd50,  8'd56,  8'd63,  8'd71,
      8'd80,  8'd90,  8'd101, 8'd113, 8'd127, 8'd144, 8'd162, 8'd182,
      8'd203, 8'd226, 8'd255, 8'd255
   };

   localparam logic [4:0] BetaTab [52] = '{
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd2,  5'd2,  5'd2,  5'd3,  5'd3,  5'd3,  5'd3,  5'd4,
      5'd4,  5'd4,  5'd6,  5'd6,  5'd7,  5'd7,  5'd8,  5'd8,
      5'd9,  5'd9,  5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12,
      5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd16, 5'd16,
      5'd17, 5'd17, 5'd18, 5'd18
   };

   // tc0 per indexA, columns for bS 1, 2, 3
   localparam logic [4:0] Tc0Tab [52][3] = '{
      '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd0},  '{5'd0, 5'd0, 5'd1},
      '{5'd0, 5'd0, 5'd1},  '{5'd0, 5'd0, 5'd1},  '{5'd0, 5'd0, 5'd1},
      '{5'd0, 5'd1, 5'd1},  '{5'd0, 5'd1, 5'd1},  '{5'd1, 5'd1, 5'd1},
      '{5'd1, 5'd1, 5'd1},  '{5'd1, 5'd1, 5'd1},  '{5'd1, 5'd1, 5'd1},
      '{5'd1, 5'd1, 5'd2},  '{5'd1, 5'd1, 5'd2},  '{5'd1, 5'd1, 5'd2},
      '{5'd1, 5'd1, 5'd2},  '{5'd1, 5'd2, 5'd3},  '{5'd1, 5'd2, 5'd3},
      '{5'd2, 5'd2, 5'd3},  '{5'd2, 5'd2, 5'd4},  '{5'd2, 5'd3, 5'd4},
      '{5'd2, 5'd3, 5'd4},  '{5'd3, 5'd3, 5'd5},  '{5'd3, 5'd4, 5'd6},
      '{5'd3, 5'd4, 5'd6},  '{5'd4, 5'd5, 5'd7},  '{5'd4, 5'd5, 5'd8},
      '{5'd4, 5'd6, 5'd9},  '{5'd5, 5'd7, 5'd10}, '{5'd6, 5'd8, 5'd11},
      '{5'd6, 5'd8, 5'd13}, '{5'd7, 5'd10, 5'd14}, '{5'd8, 5'd11, 5'd16},
      '{5'd9, 5'd12, 5'd18}, '{5'd10, 5'd13, 5'd20}, '{5'd11, 5'd15, 5'd23},
      '{5'd13, 5'd17, 5'd25}
   };

   typedef struct packed {
      logic [7:0] p3;
      logic [7:0] p2;
      logic [7:0] p1;
      logic [7:0] p0;
      logic [7:0] q0;
      logic [7:0] q1;
      logic [7:0] q2;
      logic [7:0] q3;
   } line_type;

   // per-line decisions out of the table stage
   typedef struct packed {
      logic       filt_en;
      logic       strong_bs;
      logic       chroma;
      logic       ap_lt;
      logic       aq_lt;
      logic       small_gap;
      logic [4:0] tc0;
   } ctl_type;

   // candidate values out of the tap stage
   typedef struct packed {
      logic signed [8:0] delta_raw;
      logic [4:0]        tc;
      logic [7:0]        p1_tgt;
      logic [7:0]        q1_tgt;
      logic [7:0]        sp0;
      logic [7:0]        sp1;
      logic [7:0]        sp2;
      logic [7:0]        sq0;
      logic [7:0]        sq1;
      logic [7:0]        sq2;
      logic [7:0]        wp0;
      logic [7:0]        wq0;
   } cand_type;

   typedef struct packed {
      logic [7:0] p2;
      logic [7:0] p1;
      logic [7:0] p0;
      logic [7:0] q0;
      logic [7:0] q1;
      logic [7:0] q2;
   } res_type;

endpackage

// File: rtl/core/dbf_if.sv
interface dbf_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [2:0] strength;
   logic [5:0] edge_qp;
   logic [7:0] p3_in;
   logic [7:0] p2_in;
   logic [7:0] p1_in;
   logic [7:0] p0_in;
   logic [7:0] q0_in;
   logic [7:0] q1_in;
   logic [7:0] q2_in;
   logic [7:0] q3_in;

   modport source (
      output valid, cmd, strength, edge_qp,
      output p3_in, p2_in, p1_in, p0_in, q0_in, q1_in, q2_in, q3_in,
      input  ready
   );
   modport sink (
      input  valid, cmd, strength, edge_qp,
      input  p3_in, p2_in, p1_in, p0_in, q0_in, q1_in, q2_in, q3_in,
      output ready
   );
endinterface

interface dbf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] p2_out;
   logic [7:0] p1_out;
   logic [7:0] p0_out;
   logic [7:0] q0_out;
   logic [7:0] q1_out;
   logic [7:0] q2_out;

   modport source (
      output valid, p2_out, p1_out, p0_out, q0_out, q1_out, q2_out,
      input  ready
   );
   modport sink (
      input  valid, p2_out, p1_out, p0_out, q0_out, q1_out, q2_out,
      output ready
   );
endinterface

// File: rtl/core/dbf_tap_calc.sv
// Tap sums for both filter kinds; selection and clipping happen downstream.
module dbf_tap_calc (
   input  dbf_pkg::line_type line,
   input  dbf_pkg::ctl_type  ctl,
   output dbf_pkg::cand_type cand
);

   logic signed [11:0] delta_sum;
   logic signed [11:0] delta_shr;
   logic [8:0]         avg_sum;
   logic [7:0]         avg;
   logic [8:0]         p1_sum;
   logic [8:0]         q1_sum;
   logic [10:0]        sp0_sum;
   logic [9:0]         sp1_sum;
   logic [10:0]        sp2_sum;
   logic [10:0]        sq0_sum;
   logic [9:0]         sq1_sum;
   logic [10:0]        sq2_sum;
   logic [9:0]         wp0_sum;
   logic [9:0]         wq0_sum;

   always_comb begin
      // 4*(q0-p0) + (p1-q1) + 4, then floor divide by 8
      delta_sum = $signed({2'b00, line.q0, 2'b00}) - $signed({2'b00, line.p0, 2'b00})
                + $signed({4'b0000, line.p1}) - $signed({4'b0000, line.q1}) + 12'sd4;
      delta_shr = delta_sum >>> 3;

      avg_sum = {1'b0, line.p0} + {1'b0, line.q0} + 9'd1;
      avg     = avg_sum[8:1];
      p1_sum  = {1'b0, line.p2} + {1'b0, avg};
      q1_sum  = {1'b0, line.q2} + {1'b0, avg};

      sp0_sum = {3'b000, line.p2} + {2'b00, line.p1, 1'b0} + {2'b00, line.p0, 1'b0}
              + {2'b00, line.q0, 1'b0} + {3'b000, line.q1} + 11'd4;
      sp1_sum = {2'b00, line.p2} + {2'b00, line.p1} + {2'b00, line.p0}
              + {2'b00, line.q0} + 10'd2;
      sp2_sum = {2'b00, line.p3, 1'b0} + {2'b00, line.p2, 1'b0} + {3'b000, line.p2}
              + {3'b000, line.p1} + {3'b000, line.p0} + {3'b000, line.q0} + 11'd4;

      sq0_sum = {3'b000, line.q2} + {2'b00, line.q1, 1'b0} + {2'b00, line.q0, 1'b0}
              + {2'b00, line.p0, 1'b0} + {3'b000, line.p1} + 11'd4;
      sq1_sum = {2'b00, line.q2} + {2'b00, line.q1} + {2'b00, line.q0}
              + {2'b00, line.p0} + 10'd2;
      sq2_sum = {2'b00, line.q3, 1'b0} + {2'b00, line.q2, 1'b0} + {3'b000, line.q2}
              + {3'b000, line.q1} + {3'b000, line.q0} + {3'b000, line.p0} + 11'd4;

      // three-tap average used at bS 4 by chroma and by the fallback strong path
      wp0_sum = {1'b0, line.p1, 1'b0} + {2'b00, line.p0} + {2'b00, line.q1} + 10'd2;
      wq0_sum = {1'b0, line.q1, 1'b0} + {2'b00, line.q0} + {2'b00, line.p1} + 10'd2;

      cand.delta_raw = delta_shr[8:0];
      if (ctl.chroma) begin
         cand.tc = ctl.tc0 + 5'd1;
      end else begin
         cand.tc = ctl.tc0 + {4'b0000, ctl.ap_lt} + {4'b0000, ctl.aq_lt};
      end
      cand.p1_tgt = p1_sum[8:1];
      cand.q1_tgt = q1_sum[8:1];
      cand.sp0    = sp0_sum[10:3];
      cand.sp1    = sp1_sum[9:2];
      cand.sp2    = sp2_sum[10:3];
      cand.sq0    = sq0_sum[10:3];
      cand.sq1    = sq1_sum[9:2];
      cand.sq2    = sq2_sum[10:3];
      cand.wp0    = wp0_sum[9:2];
      cand.wq0    = wq0_sum[9:2];
   end

endmodule

// File: rtl/core/deblock_edge_line_filter.sv
// Four register stages lie between request acceptance and rsp_chan.valid,
// the first loaded at the accepting edge.
// Throughput: one transaction per cycle; a stall at the response holds each full
// stage with no empty stage after it, and empty stages still fill, so no bubbles are added.
// The four pipeline stages: index clip and distances, table lookup
// and decisions, tap sums, clip and select into the output register.
// Reset (synchronous): all stage valid bits and both offset registers clear to 0.
module deblock_edge_line_filter (
   input  logic         clock,
   input  logic         reset,
   dbf_req_if.sink      req_chan,
   dbf_rsp_if.source    rsp_chan,
   input  logic         csr_we,
   input  logic [dbf_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [4:0]   csr_wdata
);

   // ---------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------
   logic signed [4:0] alpha_off_ff;
   logic signed [4:0] beta_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_off_ff <= '0;
         beta_off_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            dbf_pkg::CsrAlphaOffset: alpha_off_ff <= csr_wdata;
            dbf_pkg::CsrBetaOffset:  beta_off_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline flow: a stage loads when it is empty or its successor moves
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic adv1, adv2, adv3, adv_out;

   always_comb begin
      adv_out = !rsp_valid_ff || rsp_chan.ready;
      adv3    = !s3_valid_ff  || adv_out;
      adv2    = !s2_valid_ff  || adv3;
      adv1    = !s1_valid_ff  || adv2;
   end

   assign req_chan.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1)    s1_valid_ff  <= req_chan.valid;
         if (adv2)    s2_valid_ff  <= s1_valid_ff;
         if (adv3)    s3_valid_ff  <= s2_valid_ff;
         if (adv_out) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: clip indexA/indexB, clamp bS, sample distances
   // ---------------------------------------------------------------
   dbf_pkg::line_type s1_line_in, s1_line_ff;
   logic              s1_chroma_ff;
   logic [2:0]        s1_bs_in, s1_bs_ff;
   logic [5:0]        s1_ia_in, s1_ia_ff, s1_ib_in, s1_ib_ff;
   logic [7:0]        s1_dpq_in, s1_dpq_ff, s1_dp1_in, s1_dp1_ff;
   logic [7:0]        s1_dq1_in, s1_dq1_ff, s1_ap_in, s1_ap_ff, s1_aq_in, s1_aq_ff;
   logic signed [7:0] sum_a, sum_b;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [5:0] clip_index(input logic signed [7:0] v);
      logic [5:0] r;
      if (v < 8'sd0) begin
         r = '0;
      end else if (v > $signed({2'b00, dbf_pkg::MaxIndex})) begin
         r = dbf_pkg::MaxIndex;
      end else begin
         r = v[5:0];
      end
      return r;
   endfunction

   always_comb begin
      s1_line_in.p3 = req_chan.p3_in;
      s1_line_in.p2 = req_chan.p2_in;
      s1_line_in.p1 = req_chan.p1_in;
      s1_line_in.p0 = req_chan.p0_in;
      s1_line_in.q0 = req_chan.q0_in;
      s1_line_in.q1 = req_chan.q1_in;
      s1_line_in.q2 = req_chan.q2_in;
      s1_line_in.q3 = req_chan.q3_in;

      // edge_qp is unsigned, offsets sign-extend
      sum_a    = $signed({2'b00, req_chan.edge_qp}) + {{3{alpha_off_ff[4]}}, alpha_off_ff};
      sum_b    = $signed({2'b00, req_chan.edge_qp}) + {{3{beta_off_ff[4]}}, beta_off_ff};
      s1_ia_in = clip_index(sum_a);
      s1_ib_in = clip_index(sum_b);

      // bS 5..7 behave as bS 4
      s1_bs_in = (req_chan.strength > dbf_pkg::StrongBs) ? dbf_pkg::StrongBs
                                                         : req_chan.strength;

      s1_dpq_in = abs_diff(req_chan.p0_in, req_chan.q0_in);
      s1_dp1_in = abs_diff(req_chan.p1_in, req_chan.p0_in);
      s1_dq1_in = abs_diff(req_chan.q1_in, req_chan.q0_in);
      s1_ap_in  = abs_diff(req_chan.p2_in, req_chan.p0_in);
      s1_aq_in  = abs_diff(req_chan.q2_in, req_chan.q0_in);
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_line_ff   <= s1_line_in;
         s1_chroma_ff <= req_chan.cmd;
         s1_bs_ff     <= s1_bs_in;
         s1_ia_ff     <= s1_ia_in;
         s1_ib_ff     <= s1_ib_in;
         s1_dpq_ff    <= s1_dpq_in;
         s1_dp1_ff    <= s1_dp1_in;
         s1_dq1_ff    <= s1_dq1_in;
         s1_ap_ff     <= s1_ap_in;
         s1_aq_ff     <= s1_aq_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: alpha/beta/tc0 lookup, activity test and filter decisions
   // ---------------------------------------------------------------
   dbf_pkg::line_type s2_line_ff;
   dbf_pkg::ctl_type  s2_ctl_in, s2_ctl_ff;
   logic [7:0]        alpha;
   logic [7:0]        beta;
   logic [7:0]        small_lim;

   always_comb begin
      alpha     = dbf_pkg::AlphaTab[s1_ia_ff];
      beta      = {3'b000, dbf_pkg::BetaTab[s1_ib_ff]};
      small_lim = {2'b00, alpha[7:2]} + 8'd2;

      s2_ctl_in.filt_en   = (s1_bs_ff != 3'd0) && (alpha != 8'd0) && (beta != 8'd0)
                         && (s1_dpq_ff < alpha) && (s1_dp1_ff < beta)
                         && (s1_dq1_ff < beta);
      s2_ctl_in.strong_bs = (s1_bs_ff == dbf_pkg::StrongBs);
      s2_ctl_in.chroma    = s1_chroma_ff;
      s2_ctl_in.ap_lt     = (s1_ap_ff < beta);
      s2_ctl_in.aq_lt     = (s1_aq_ff < beta);
      s2_ctl_in.small_gap = (s1_dpq_ff < small_lim);
      // tc0 only matters for bS 1..3
      if ((s1_bs_ff != 3'd0) && (s1_bs_ff != dbf_pkg::StrongBs)) begin
         s2_ctl_in.tc0 = dbf_pkg::Tc0Tab[s1_ia_ff][s1_bs_ff[1:0] - 2'd1];
      end else begin
         s2_ctl_in.tc0 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_line_ff <= s1_line_ff;
         s2_ctl_ff  <= s2_ctl_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: tap sums
   // ---------------------------------------------------------------
   dbf_pkg::line_type s3_line_ff;
   dbf_pkg::ctl_type  s3_ctl_ff;
   dbf_pkg::cand_type s3_cand_in, s3_cand_ff;

   dbf_tap_calc u_tap_calc (
      .line (s2_line_ff),
      .ctl  (s2_ctl_ff),
      .cand (s3_cand_in)
   );

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_line_ff <= s2_line_ff;
         s3_ctl_ff  <= s2_ctl_ff;
         s3_cand_ff <= s3_cand_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: clip deltas, saturate, pick per-sample result
   // ---------------------------------------------------------------
   dbf_pkg::res_type  rsp_in, rsp_ff;
   logic signed [8:0] delta;
   logic signed [8:0] p1_d, q1_d;
   logic signed [9:0] p0_sum, q0_sum;
   logic [8:0]        p1_new, q1_new;
   logic [7:0]        np0_norm, nq0_norm;
   logic              p_strong, q_strong;

   function automatic logic signed [8:0] clip_sym(input logic signed [8:0] v,
                                                 input logic [4:0] lim);
      logic signed [8:0] l;
      logic signed [8:0] r;
      l = $signed({4'b0000, lim});
      if (v > l) begin
         r = l;
      end else if (v < -l) begin
         r = -l;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [7:0] sat_pixel(input logic signed [9:0] v);
      logic [7:0] r;
      if (v < 10'sd0) begin
         r = 8'd0;
      end else if (v > 10'sd255) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   always_comb begin
      delta    = clip_sym(s3_cand_ff.delta_raw, s3_cand_ff.tc);
      p0_sum   = $signed({2'b00, s3_line_ff.p0}) + {delta[8], delta};
      q0_sum   = $signed({2'b00, s3_line_ff.q0}) - {delta[8], delta};
      np0_norm = sat_pixel(p0_sum);
      nq0_norm = sat_pixel(q0_sum);

      // p1/q1 move toward their target by at most tc0; stays within 0..255
      p1_d   = clip_sym($signed({1'b0, s3_cand_ff.p1_tgt}) - $signed({1'b0, s3_line_ff.p1}),
                        s3_ctl_ff.tc0);
      q1_d   = clip_sym($signed({1'b0, s3_cand_ff.q1_tgt}) - $signed({1'b0, s3_line_ff.q1}),
                        s3_ctl_ff.tc0);
      p1_new = {1'b0, s3_line_ff.p1} + p1_d;
      q1_new = {1'b0, s3_line_ff.q1} + q1_d;

      p_strong = !s3_ctl_ff.chroma && s3_ctl_ff.ap_lt && s3_ctl_ff.small_gap;
      q_strong = !s3_ctl_ff.chroma && s3_ctl_ff.aq_lt && s3_ctl_ff.small_gap;

      rsp_in.p2 = s3_line_ff.p2;
      rsp_in.p1 = s3_line_ff.p1;
      rsp_in.p0 = s3_line_ff.p0;
      rsp_in.q0 = s3_line_ff.q0;
      rsp_in.q1 = s3_line_ff.q1;
      rsp_in.q2 = s3_line_ff.q2;

      if (s3_ctl_ff.filt_en && !s3_ctl_ff.strong_bs) begin
         rsp_in.p0 = np0_norm;
         rsp_in.q0 = nq0_norm;
         if (!s3_ctl_ff.chroma && s3_ctl_ff.ap_lt) rsp_in.p1 = p1_new[7:0];
         if (!s3_ctl_ff.chroma && s3_ctl_ff.aq_lt) rsp_in.q1 = q1_new[7:0];
      end else if (s3_ctl_ff.filt_en) begin
         if (p_strong) begin
            rsp_in.p0 = s3_cand_ff.sp0;
            rsp_in.p1 = s3_cand_ff.sp1;
            rsp_in.p2 = s3_cand_ff.sp2;
         end else begin
            rsp_in.p0 = s3_cand_ff.wp0;
         end
         if (q_strong) begin
            rsp_in.q0 = s3_cand_ff.sq0;
            rsp_in.q1 = s3_cand_ff.sq1;
            rsp_in.q2 = s3_cand_ff.sq2;
         end else begin
            rsp_in.q0 = s3_cand_ff.wq0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.p2_out = rsp_ff.p2;
   assign rsp_chan.p1_out = rsp_ff.p1;
   assign rsp_chan.p0_out = rsp_ff.p0;
   assign rsp_chan.q0_out = rsp_ff.q0;
   assign rsp_chan.q1_out = rsp_ff.q1;
   assign rsp_chan.q2_out = rsp_ff.q2;

endmodule

// File: rtl/core/dbf_checker.sv
module dbf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] p2_out,
   input logic [7:0] p1_out,
   input logic [7:0] p0_out,
   input logic [7:0] q0_out,
   input logic [7:0] q1_out,
   input logic [7:0] q2_out
);

   // transactions in flight: accepted minus delivered
   logic [2:0] count_ff;
   logic [2:0] count_in;

   always_comb begin
      count_in = count_ff + {2'b00, req_valid && req_ready}
                          - {2'b00, rsp_valid && rsp_ready};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(p2_out) && $stable(p1_out) && $stable(p0_out)
                                  && $stable(q0_out) && $stable(q1_out) && $stable(q2_out))
      else $error("response payload changed while stalled");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request side blocked without a response stall");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("more transactions in flight than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != 3'd0)
      else $error("response without an accepted request");

endmodule

bind deblock_edge_line_filter dbf_checker u_dbf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .p2_out    (rsp_chan.p2_out),
   .p1_out    (rsp_chan.p1_out),
   .p0_out    (rsp_chan.p0_out),
   .q0_out    (rsp_chan.q0_out),
   .q1_out    (rsp_chan.q1_out),
   .q2_out    (rsp_chan.q2_out)
);
